FILE: sv/lsef_pkg.sv
// Package for the LSB steganography frame extractor.
// It holds the item structs, the configuration and state types, and the phase and status codes.
// It has no dependencies.
`default_nettype none

package lsef_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_HEADER_LEN     = 2'd0;
  localparam logic [1:0] CFG_MAGIC_COUNT    = 2'd1;
  localparam logic [1:0] CFG_EXPECTED_MAGIC = 2'd2;
  localparam logic [1:0] CFG_EXT_MAX        = 2'd3;

  // Decoder phases.
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_MLEN   = 3'd1;
  localparam logic [2:0] PH_MCHAR  = 3'd2;
  localparam logic [2:0] PH_ELEN   = 3'd3;
  localparam logic [2:0] PH_ECHAR  = 3'd4;
  localparam logic [2:0] PH_DLEN   = 3'd5;
  localparam logic [2:0] PH_DCHAR  = 3'd6;
  localparam logic [2:0] PH_DONE   = 3'd7;

  // Section tags.
  localparam logic [1:0] SEC_MAGIC = 2'd0;
  localparam logic [1:0] SEC_EXT   = 2'd1;
  localparam logic [1:0] SEC_DATA  = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK              = 2'd0;
  localparam logic [1:0] ST_BAD_MAGIC_COUNT = 2'd1;
  localparam logic [1:0] ST_MISMATCH        = 2'd2;
  localparam logic [1:0] ST_EXT_LONG        = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [9:0]  HEADER_LEN_RST     = 10'd54;
  localparam logic [3:0]  MAGIC_COUNT_RST    = 4'd2;
  localparam logic [63:0] EXPECTED_MAGIC_RST = 64'd0;
  localparam logic [2:0]  EXT_MAX_RST        = 3'd5;

  // Bit counts that close a length word and a character.
  localparam logic [4:0] WORD_LAST_BIT = 5'd31;
  localparam logic [4:0] CHAR_LAST_BIT = 5'd7;

  typedef struct packed {
    logic [7:0] cover_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic [1:0] section;
    logic       last;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [9:0]  header_len;
    logic [3:0]  magic_count;
    logic [63:0] expected_magic;
    logic [2:0]  ext_max;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [9:0]  skip_count;
    logic [4:0]  bit_count;
    logic [31:0] shift_word;
    logic [31:0] remaining_count;
    logic [3:0]  magic_index;
    logic        magic_match;
  } dec_state_t;

  localparam dec_state_t DEC_STATE_RST = '{
    phase:           PH_HEADER,
    skip_count:      10'd0,
    bit_count:       5'd0,
    shift_word:      32'd0,
    remaining_count: 32'd0,
    magic_index:     4'd0,
    magic_match:     1'b1
  };

endpackage : lsef_pkg

`default_nettype wire

FILE: sv/lsef_cfg_regs.sv
// Configuration registers of the LSB steganography frame extractor.
// Depends on lsef_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module lsef_cfg_regs import lsef_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Writes are taken in any cycle.
  assign cfg_ready_o = 1'b1;

  // Register write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_HEADER_LEN:     cfg_d.header_len     = cfg_data_i[9:0];
        CFG_MAGIC_COUNT:    cfg_d.magic_count    = cfg_data_i[3:0];
        CFG_EXPECTED_MAGIC: cfg_d.expected_magic = cfg_data_i;
        CFG_EXT_MAX:        cfg_d.ext_max        = cfg_data_i[2:0];
        default:            cfg_d                = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_len     <= HEADER_LEN_RST;
      cfg_q.magic_count    <= MAGIC_COUNT_RST;
      cfg_q.expected_magic <= EXPECTED_MAGIC_RST;
      cfg_q.ext_max        <= EXT_MAX_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule : lsef_cfg_regs

`default_nettype wire

FILE: sv/lsef_step.sv
// Per-item decode step: next decoder state and the optional result for one cover byte.
// Purely combinational. Depends on lsef_pkg for the types and codes.
`default_nettype none

module lsef_step import lsef_pkg::*; (
  input  cfg_t       cfg_i,
  input  dec_state_t st_i,
  input  in_item_t   item_i,
  output dec_state_t st_o,
  output logic       res_valid_o,
  output out_item_t  res_o
);

  dec_state_t  st;
  logic        go;
  logic [31:0] shift_v;
  logic [7:0]  char_v;
  logic [7:0]  want_v;
  logic [31:0] rem_v;
  logic        word_done;
  logic        char_done;

  // Expected magic character at the current position; positions past the eighth are zero.
  assign want_v = st_i.magic_index[3] ? 8'h00 :
                  cfg_i.expected_magic[{st_i.magic_index[2:0], 3'b000} +: 8];

  always_comb begin
    st          = item_i.restart ? DEC_STATE_RST : st_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    go          = 1'b1;
    shift_v     = 32'd0;
    char_v      = 8'd0;
    rem_v       = 32'd0;
    word_done   = 1'b0;
    char_done   = 1'b0;

    // Halted, or still inside the header.
    if (st.phase == PH_DONE) begin
      go = 1'b0;
    end else if (st.phase == PH_HEADER) begin
      if (st.skip_count < cfg_i.header_len) begin
        st.skip_count = st.skip_count + 10'd1;
        go            = 1'b0;
      end else begin
        st.phase      = PH_MLEN;
        st.bit_count  = 5'd0;
        st.shift_word = 32'd0;
      end
    end

    if (go) begin
      shift_v       = {st.shift_word[30:0], item_i.cover_byte[0]};
      word_done     = (st.bit_count == WORD_LAST_BIT);
      char_done     = (st.bit_count == CHAR_LAST_BIT);
      char_v        = shift_v[7:0];
      rem_v         = st.remaining_count - 32'd1;
      st.shift_word = shift_v;

      if (st.phase == PH_MLEN || st.phase == PH_ELEN || st.phase == PH_DLEN) begin
        // Length words.
        if (!word_done) begin
          st.bit_count = st.bit_count + 5'd1;
        end else begin
          st.bit_count       = 5'd0;
          st.shift_word      = 32'd0;
          st.remaining_count = shift_v;
          if (st.phase == PH_MLEN) begin
            if (shift_v != {28'd0, cfg_i.magic_count}) begin
              st.phase    = PH_DONE;
              res_valid_o = 1'b1;
              res_o       = '{8'd0, 1'b0, SEC_MAGIC, 1'b1, ST_BAD_MAGIC_COUNT};
            end else begin
              st.magic_index = 4'd0;
              st.phase       = (shift_v == 32'd0) ? PH_ELEN : PH_MCHAR;
            end
          end else if (st.phase == PH_ELEN) begin
            if (shift_v > {29'd0, cfg_i.ext_max}) begin
              st.phase    = PH_DONE;
              res_valid_o = 1'b1;
              res_o       = '{8'd0, 1'b0, SEC_EXT, 1'b1, ST_EXT_LONG};
            end else if (shift_v == 32'd0) begin
              if (!st.magic_match) begin
                st.phase    = PH_DONE;
                res_valid_o = 1'b1;
                res_o       = '{8'd0, 1'b0, SEC_EXT, 1'b1, ST_MISMATCH};
              end else begin
                st.phase = PH_DLEN;
              end
            end else begin
              st.phase = PH_ECHAR;
            end
          end else begin
            if (shift_v == 32'd0) begin
              st.phase    = PH_DONE;
              res_valid_o = 1'b1;
              res_o       = '{8'd0, 1'b0, SEC_DATA, 1'b1, ST_OK};
            end else begin
              st.phase = PH_DCHAR;
            end
          end
        end
      end else begin
        // Characters.
        if (!char_done) begin
          st.bit_count = st.bit_count + 5'd1;
        end else begin
          st.bit_count       = 5'd0;
          st.shift_word      = 32'd0;
          st.remaining_count = rem_v;
          res_valid_o        = 1'b1;
          if (st.phase == PH_MCHAR) begin
            if (char_v != want_v) begin
              st.magic_match = 1'b0;
            end
            st.magic_index = st.magic_index + 4'd1;
            if (rem_v == 32'd0) begin
              st.phase = PH_ELEN;
            end
            res_o = '{char_v, 1'b1, SEC_MAGIC, 1'b0, ST_OK};
          end else if (st.phase == PH_ECHAR) begin
            res_o = '{char_v, 1'b1, SEC_EXT, 1'b0, ST_OK};
            if (rem_v == 32'd0) begin
              if (!st.magic_match) begin
                st.phase = PH_DONE;
                res_o    = '{char_v, 1'b1, SEC_EXT, 1'b1, ST_MISMATCH};
              end else begin
                st.phase = PH_DLEN;
              end
            end
          end else begin
            res_o = '{char_v, 1'b1, SEC_DATA, 1'b0, ST_OK};
            if (rem_v == 32'd0) begin
              st.phase = PH_DONE;
              res_o    = '{char_v, 1'b1, SEC_DATA, 1'b1, ST_OK};
            end
          end
        end
      end
    end

    st_o = st;
  end

endmodule : lsef_step

`default_nettype wire

FILE: sv/lsb_stego_frame_extractor_unit.sv
// LSB steganography frame extractor, top level: input register, decode step, result register.
// An item's result, if any, is registered once the combinational step decodes the held item.
// Throughput: one cover byte per cycle while the result register is free or being emptied.
// Reset (rst_ni low, asynchronous): non-data registers to defaults, decoder to header skip.
// Depends on lsef_pkg, lsef_cfg_regs and lsef_step.
`default_nettype none

module lsb_stego_frame_extractor_unit import lsef_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_item_t    in_item_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_item_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);

  cfg_t       cfg;
  dec_state_t st_q, st_d;
  in_item_t   in_item_q;
  logic       in_valid_q;
  out_item_t  out_item_q, res;
  logic       out_valid_q;
  logic       res_valid;
  logic       fire;

  lsef_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lsef_step u_step (
    .cfg_i       (cfg),
    .st_i        (st_q),
    .item_i      (in_item_q),
    .st_o        (st_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // The held item is decoded when the result register is free or being emptied.
  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_item_i;
    end
  end

  // Decoder state advances once per decoded item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= DEC_STATE_RST;
    end else if (fire) begin
      st_q <= st_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Any error status closes the file.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_item_q.status == ST_OK || out_item_q.last))
    else $error("error status without last");

  // A result without a character carries a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_item_q.has_byte) |-> (out_item_q.data_byte == 8'd0))
    else $error("empty result with nonzero byte");

  // A last result leaves the decoder halted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && res_valid && res.last) |=> (st_q.phase == PH_DONE))
    else $error("decoder not halted after last result");

  // Character phases never count past eight bits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.phase == PH_MCHAR || st_q.phase == PH_ECHAR || st_q.phase == PH_DCHAR)
      |-> (st_q.bit_count <= CHAR_LAST_BIT))
    else $error("character bit count overrun");

  // Input stalls only while an item is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without cause");

endmodule : lsb_stego_frame_extractor_unit

`default_nettype wire
